// ===== sv/brians_brain_generation_step_assert.svh =====
// Assertion macros for the generation step block.
// Both macros sample on clock and are disabled while reset is high.
`ifndef BRIANS_BRAIN_GENERATION_STEP_ASSERT_SVH
`define BRIANS_BRAIN_GENERATION_STEP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BBGS_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BBGS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/bbgs_pkg.sv =====
// Shared types and constants for the generation step block.
// No dependencies; used by bbgs_out_fifo and the top level.
package bbgs_pkg;

   localparam int unsigned CSR_DATA_W = 16;
   localparam int unsigned COLS_CFG_W = 12;
   localparam int unsigned ROWS_W     = 16;
   localparam int unsigned TDATA_W    = 8;
   localparam int unsigned QUEUE_DEPTH = 3;

   localparam logic [COLS_CFG_W-1:0] COLS_RESET = 12'd1280;
   localparam logic [ROWS_W-1:0]     ROWS_RESET = 16'd720;
   localparam logic [ROWS_W-1:0]     ROWS_LIMIT = 16'd65534;

   localparam logic [1:0] CELL_OFF   = 2'd0;
   localparam logic [1:0] CELL_ON    = 2'd1;
   localparam logic [1:0] CELL_DYING = 2'd2;

   typedef enum logic [0:0] {
      REG_GRID_COLUMNS = 1'b0,
      REG_GRID_ROWS    = 1'b1
   } csr_index_type;

   typedef enum logic [0:0] {
      OP_CELL  = 1'b0,
      OP_DRAIN = 1'b1
   } op_type;

   typedef struct packed {
      logic       frame_end;
      logic [1:0] next_state;
   } result_type;

endpackage

// ===== sv/bbgs_out_fifo.sv =====
// Three-entry result queue between the compute stage and the response channel.
// Depends on bbgs_pkg for result_type and the queue depth.
module bbgs_out_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  bbgs_pkg::result_type push_data,
   input  logic                pop_ready,
   output logic                out_valid,
   output bbgs_pkg::result_type out_data,
   output logic [1:0]          count
);

   bbgs_pkg::result_type slot_ff [bbgs_pkg::QUEUE_DEPTH];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign out_valid = (count_ff != 2'd0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign count     = count_ff;
   assign pop       = out_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == 2'(bbgs_pkg::QUEUE_DEPTH - 1)) ? 2'd0 : wr_ptr_ff + 2'd1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == 2'(bbgs_pkg::QUEUE_DEPTH - 1)) ? 2'd0 : rd_ptr_ff + 2'd1;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/brians_brain_generation_step.sv =====
// One Brian's Brain generation over a raster-order cell stream, one cell per request.
// Requests are taken every cycle while the three-entry result queue has room; each
// result appears columns+1 requests after its cell, and after the last cell of a frame
// columns+1 drain requests flush the rest. The rows above the input position live in
// one line memory of MAX_COLUMNS entries (two cells per entry) that is read when a
// request is taken and written back in the next cycle; a request at the column still
// being written takes the pending data by forwarding. The memory needs no clearing
// pass after reset. A drain while no frame is in progress is taken and dropped.
// Depends on bbgs_pkg, bbgs_out_fifo and brians_brain_generation_step_assert.svh.
module brians_brain_generation_step #(
   parameter int unsigned MAX_COLUMNS = 2048
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [bbgs_pkg::TDATA_W-1:0]    req_tdata,   // [1:0] cell_state
   input  logic                            req_tuser,   // [0] operation
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [bbgs_pkg::TDATA_W-1:0]    rsp_tdata,   // [1:0] next_state
   output logic                            rsp_tlast,
   input  logic                            csr_we,
   input  logic [0:0]                      csr_index,
   input  logic [bbgs_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int unsigned AW = $clog2(MAX_COLUMNS);
   localparam int unsigned CW = AW + 1;
   localparam int unsigned OW = CW + 1;
   localparam int unsigned EW = (CW > bbgs_pkg::COLS_CFG_W) ? CW : bbgs_pkg::COLS_CFG_W;
   localparam int unsigned RW = bbgs_pkg::ROWS_W;

   // Configuration.
   logic [bbgs_pkg::COLS_CFG_W-1:0] grid_columns_ff;
   logic [RW-1:0]                   grid_rows_ff;
   logic [EW-1:0]                   cols_ext;
   logic [CW-1:0]                   cols_eff;
   logic [RW-1:0]                   rows_eff;

   // Position counters, kept at the request side.
   logic [AW-1:0] in_col_ff, in_col_in;
   logic [RW-1:0] in_row_ff, in_row_in;
   logic [AW-1:0] out_col_ff, out_col_in;
   logic [RW-1:0] out_row_ff, out_row_in;
   logic [OW-1:0] owed_ff, owed_in;

   // Stage one: the request whose line data is being read.
   logic          s1_valid_ff;
   logic [AW-1:0] s1_addr_ff;
   logic [1:0]    s1_cell_ff;
   logic          s1_emit_ff, s1_last_ff;
   logic          s1_up_ff, s1_down_ff, s1_left_ff, s1_right_ff;
   logic          fwd_ff;
   logic [3:0]    fwd_data_ff;
   logic [3:0]    mem_rd_ff;

   // Line memory: [3:2] row two above the input, [1:0] row just above.
   logic [3:0] line_mem [MAX_COLUMNS];

   logic [1:0] win_ff [3][3];
   logic [1:0] win_in [3][3];
   logic [1:0] win_new [3][3];

   logic          take, drain, ignore, advance;
   logic          in_col_wrap;
   logic [AW-1:0] ic0;
   logic [RW-1:0] ir0;
   logic          out_col_wrap;
   logic [AW-1:0] oc0;
   logic [RW-1:0] or0;
   logic [CW-1:0] ic_inc, oc_inc;
   logic [1:0]    cell_eff;
   logic          emit, up, down, left, right, last, frame_done;
   logic [3:0]    rd_eff;
   logic [3:0]    ones;
   logic          row_ok [3];
   logic          col_ok [3];
   logic [1:0]    next_state;
   logic [1:0]    q_count;
   logic          q_push;
   logic          s1_close, ctr_idle, win_idle;
   bbgs_pkg::result_type q_in, q_out;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_columns_ff <= bbgs_pkg::COLS_RESET;
         grid_rows_ff    <= bbgs_pkg::ROWS_RESET;
      end else if (csr_we) begin
         unique case (bbgs_pkg::csr_index_type'(csr_index))
            bbgs_pkg::REG_GRID_COLUMNS: begin
               grid_columns_ff <= csr_wdata[bbgs_pkg::COLS_CFG_W-1:0];
            end
            bbgs_pkg::REG_GRID_ROWS: begin
               grid_rows_ff <= csr_wdata[RW-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      cols_ext = EW'(grid_columns_ff);
      if (cols_ext == '0) begin
         cols_eff = CW'(1);
      end else if (cols_ext > EW'(MAX_COLUMNS)) begin
         cols_eff = CW'(MAX_COLUMNS);
      end else begin
         cols_eff = CW'(cols_ext);
      end
      if (grid_rows_ff == '0) begin
         rows_eff = RW'(1);
      end else if (grid_rows_ff > bbgs_pkg::ROWS_LIMIT) begin
         rows_eff = bbgs_pkg::ROWS_LIMIT;
      end else begin
         rows_eff = grid_rows_ff;
      end
   end

   // Request side: positions, masks and whether this request owes a result.
   assign take    = req_tvalid && req_tready;
   assign drain   = (bbgs_pkg::op_type'(req_tuser) == bbgs_pkg::OP_DRAIN);
   assign ignore  = drain && (in_col_ff == '0) && (in_row_ff == '0) && (owed_ff == '0);
   assign advance = take && !ignore;

   always_comb begin
      in_col_wrap  = ({1'b0, in_col_ff} >= cols_eff);
      ic0          = in_col_wrap ? '0 : in_col_ff;
      ir0          = in_col_wrap ? in_row_ff + RW'(1) : in_row_ff;
      out_col_wrap = ({1'b0, out_col_ff} >= cols_eff);
      oc0          = out_col_wrap ? '0 : out_col_ff;
      or0          = out_col_wrap ? out_row_ff + RW'(1) : out_row_ff;

      cell_eff = (drain || (ir0 >= rows_eff)) ? bbgs_pkg::CELL_OFF : req_tdata[1:0];

      ic_inc = {1'b0, ic0} + CW'(1);
      if (ic_inc >= cols_eff) begin
         in_col_in = '0;
         in_row_in = ir0 + RW'(1);
      end else begin
         in_col_in = ic_inc[AW-1:0];
         in_row_in = ir0;
      end

      emit    = (owed_ff >= ({1'b0, cols_eff} + OW'(1)));
      owed_in = emit ? owed_ff : owed_ff + OW'(1);

      up    = (or0 != '0);
      down  = (({1'b0, or0} + (RW + 1)'(1)) < {1'b0, rows_eff});
      left  = (oc0 != '0);
      right = (({1'b0, oc0} + CW'(1)) < cols_eff);
      last  = !down && !right;
      frame_done = emit && last;

      oc_inc     = {1'b0, oc0} + CW'(1);
      out_col_in = oc0;
      out_row_in = or0;
      if (emit && !last) begin
         if (oc_inc >= cols_eff) begin
            out_col_in = '0;
            out_row_in = or0 + RW'(1);
         end else begin
            out_col_in = oc_inc[AW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         owed_ff    <= '0;
      end else if (advance) begin
         if (frame_done) begin
            in_col_ff  <= '0;
            in_row_ff  <= '0;
            out_col_ff <= '0;
            out_row_ff <= '0;
            owed_ff    <= '0;
         end else begin
            in_col_ff  <= in_col_in;
            in_row_ff  <= in_row_in;
            out_col_ff <= out_col_in;
            out_row_ff <= out_row_in;
            owed_ff    <= owed_in;
         end
      end
   end

   // Stage one registers. Only the previous request can still be writing the entry
   // that this one reads, so a single forwarding register covers the hazard.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= advance;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_addr_ff  <= ic0;
         s1_cell_ff  <= cell_eff;
         s1_emit_ff  <= emit;
         s1_last_ff  <= last;
         s1_up_ff    <= up;
         s1_down_ff  <= down;
         s1_left_ff  <= left;
         s1_right_ff <= right;
         fwd_ff      <= s1_valid_ff && (s1_addr_ff == ic0);
         fwd_data_ff <= {rd_eff[1:0], s1_cell_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mem_rd_ff <= line_mem[ic0];
      end
      if (s1_valid_ff) begin
         line_mem[s1_addr_ff] <= {rd_eff[1:0], s1_cell_ff};
      end
   end

   assign rd_eff = fwd_ff ? fwd_data_ff : mem_rd_ff;

   // Window shift and the cell rule.
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         win_new[r][0] = win_ff[r][1];
         win_new[r][1] = win_ff[r][2];
      end
      win_new[0][2] = rd_eff[3:2];
      win_new[1][2] = rd_eff[1:0];
      win_new[2][2] = s1_cell_ff;

      row_ok[0] = s1_up_ff;
      row_ok[1] = 1'b1;
      row_ok[2] = s1_down_ff;
      col_ok[0] = s1_left_ff;
      col_ok[1] = 1'b1;
      col_ok[2] = s1_right_ff;

      ones = '0;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            if (row_ok[r] && col_ok[c] && !(r == 1 && c == 1) &&
                (win_new[r][c] == bbgs_pkg::CELL_ON)) begin
               ones = ones + 4'd1;
            end
         end
      end

      if (win_new[1][1] == bbgs_pkg::CELL_ON) begin
         next_state = bbgs_pkg::CELL_DYING;
      end else if (win_new[1][1] == bbgs_pkg::CELL_DYING) begin
         next_state = bbgs_pkg::CELL_OFF;
      end else if (ones == 4'd2) begin
         next_state = bbgs_pkg::CELL_ON;
      end else begin
         next_state = bbgs_pkg::CELL_OFF;
      end

      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            win_in[r][c] = (s1_emit_ff && s1_last_ff) ? bbgs_pkg::CELL_OFF : win_new[r][c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_ff[r][c] <= bbgs_pkg::CELL_OFF;
            end
         end
      end else if (s1_valid_ff) begin
         win_ff <= win_in;
      end
   end

   // Result queue. A request is taken only if its result is sure to find a slot.
   assign q_push          = s1_valid_ff && s1_emit_ff;
   assign q_in.frame_end  = s1_last_ff;
   assign q_in.next_state = next_state;

   bbgs_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .pop_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_data  (q_out),
      .count     (q_count)
   );

   assign req_tready = (({1'b0, q_count} + {2'b0, s1_valid_ff}) <= 3'(bbgs_pkg::QUEUE_DEPTH - 1));
   assign rsp_tdata  = {(bbgs_pkg::TDATA_W - 2)'(0), q_out.next_state};
   assign rsp_tlast  = q_out.frame_end;

   // Terms for the checks below.
   assign s1_close = s1_valid_ff && s1_emit_ff && s1_last_ff;
   assign ctr_idle = (in_col_ff == '0) && (in_row_ff == '0) && (owed_ff == '0);
   assign win_idle = (win_ff[1][1] == bbgs_pkg::CELL_OFF) &&
                     (win_ff[1][2] == bbgs_pkg::CELL_OFF) &&
                     (win_ff[0][2] == bbgs_pkg::CELL_OFF);

`include "brians_brain_generation_step_assert.svh"

   `BBGS_ASSERT_SAME(a_queue_room, q_push, q_count < 2'(bbgs_pkg::QUEUE_DEPTH), "queue overflow")
   `BBGS_ASSERT_SAME(a_frame_cleared, s1_close, ctr_idle, "counters not cleared at frame end")
   `BBGS_ASSERT_NEXT(a_window_cleared, s1_close, win_idle, "window not cleared after frame end")

endmodule
